@@ hdl/bfs_pkg.sv @@
// Package for the BFS level histogram: sizes, limits, actions, state codes.
// No dependencies.
`default_nettype none
package bfs_pkg;
	localparam int MaxNodes = 1024;
	localparam int MaxEdges = 8192;
	localparam int MaxDepth = 32;
	localparam logic [10:0] NodeLimit = 11'd1024;
	localparam logic [13:0] EdgeLimit = 14'd8192;
	localparam logic [4:0]  DepthTop  = 5'd31;
	localparam logic [10:0] ClearLast = 11'd1023;

	typedef enum logic [1:0] {
		ACT_START = 2'd0,
		ACT_NEIGH = 2'd1,
		ACT_RUN   = 2'd2,
		ACT_NONE  = 2'd3
	} action_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_CLEAR, ST_SEED, ST_POP, ST_LO, ST_HI, ST_RANGE,
		ST_EDGE, ST_EDGE2, ST_NEXT, ST_EMIT
	} state_t;
endpackage
`default_nettype wire

@@ hdl/bfs_if.sv @@
// Valid/ready channel interfaces for requests and results.
// Depends on nothing.
`default_nettype none
interface bfs_in_if;
	logic valid;
	logic ready;
	logic [1:0] action;
	logic [12:0] position;
	logic [13:0] value;
	modport source(output valid, action, position, value, input ready);
	modport sink(input valid, action, position, value, output ready);
endinterface

interface bfs_out_if;
	logic valid;
	logic ready;
	logic [4:0] depth;
	logic [10:0] path_count;
	logic last;
	modport source(output valid, depth, path_count, last, input ready);
	modport sink(input valid, depth, path_count, last, output ready);
endinterface
`default_nettype wire

@@ hdl/bfs_level_histogram.sv @@
// BFS level histogram top level: graph memories, visited map, queue, counts.
// Depends on bfs_pkg and bfs_if. Load requests: one per cycle while idle, back to back.
// Run: clear the visited map, seed the source, then for each dequeued node read its edge
// range and scan its edge entries until the queue is empty, then one result per cycle
// while res.ready is high. An invalid source gives its single result after the clear.
// Asynchronous active-low reset clears control state; table contents are kept.
`default_nettype none
module bfs_level_histogram (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [10:0] cfg_wdata,
	bfs_in_if.sink           req,
	bfs_out_if.source        res
);
	bfs_pkg::state_t st_q, st_d;
	logic [10:0] ncnt_q;
	logic [10:0] n_eff;
	logic [13:0] es_mem [0:bfs_pkg::MaxNodes];
	logic [10:0] nb_mem [0:bfs_pkg::MaxEdges-1];
	logic        vis_mem [0:bfs_pkg::MaxNodes-1];
	logic [14:0] q_mem [0:bfs_pkg::MaxNodes-1];
	logic [10:0] cnt_q [0:bfs_pkg::MaxDepth-1];
	logic [13:0] es_rd_q;
	logic [10:0] nb_rd_q;
	logic        vis_rd_q;
	logic [14:0] q_rd_q;
	logic [10:0] head_q, tail_q, clr_q;
	logic [9:0]  u_q;
	logic [4:0]  ud_q, deep_q, emd_q, nd;
	logic [13:0] lo_q, hi_q, lo_nx;
	logic [13:0] es_clamp;
	logic [10:0] es_addr;
	logic [12:0] nb_addr;
	logic        src_ok_q;
	logic        accept;
	logic        run_go;
	logic        nb_ok;

	assign n_eff = (ncnt_q == 11'd0) ? 11'd1 :
		(ncnt_q > bfs_pkg::NodeLimit) ? bfs_pkg::NodeLimit : ncnt_q;
	assign accept = req.valid && req.ready;
	assign run_go = accept && req.action == bfs_pkg::ACT_RUN;
	assign es_clamp = (es_rd_q > bfs_pkg::EdgeLimit) ? bfs_pkg::EdgeLimit : es_rd_q;
	assign lo_nx = lo_q + 14'd1;
	assign nd = (ud_q == bfs_pkg::DepthTop) ? bfs_pkg::DepthTop : ud_q + 5'd1;
	assign es_addr = (st_q == bfs_pkg::ST_LO) ? {1'b0, q_rd_q[14:5]} : {1'b0, u_q} + 11'd1;
	assign nb_addr = (st_q == bfs_pkg::ST_EDGE2) ? lo_nx[12:0] : lo_q[12:0];
	// neighbour entries hold an out-of-range flag above the node index
	assign nb_ok = (nb_rd_q < n_eff) && !vis_rd_q && (tail_q < bfs_pkg::NodeLimit);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ncnt_q <= 11'd1024;
		end else if (cfg_we) begin
			ncnt_q <= cfg_wdata;
		end
	end

	always_comb begin
		st_d = st_q;
		case (st_q)
			bfs_pkg::ST_IDLE: if (run_go)
				st_d = bfs_pkg::ST_CLEAR;
			bfs_pkg::ST_CLEAR: if (clr_q == bfs_pkg::ClearLast)
				st_d = src_ok_q ? bfs_pkg::ST_SEED : bfs_pkg::ST_EMIT;
			bfs_pkg::ST_SEED: st_d = bfs_pkg::ST_POP;
			bfs_pkg::ST_POP: st_d = (head_q < tail_q) ? bfs_pkg::ST_LO : bfs_pkg::ST_EMIT;
			bfs_pkg::ST_LO: st_d = bfs_pkg::ST_HI;
			bfs_pkg::ST_HI: st_d = bfs_pkg::ST_RANGE;
			bfs_pkg::ST_RANGE: st_d = (lo_q < es_clamp) ? bfs_pkg::ST_EDGE : bfs_pkg::ST_NEXT;
			bfs_pkg::ST_EDGE: st_d = bfs_pkg::ST_EDGE2;
			bfs_pkg::ST_EDGE2: st_d = (lo_nx < hi_q) ? bfs_pkg::ST_EDGE : bfs_pkg::ST_NEXT;
			bfs_pkg::ST_NEXT: st_d = bfs_pkg::ST_POP;
			bfs_pkg::ST_EMIT: if (res.ready)
				st_d = (emd_q == deep_q) ? bfs_pkg::ST_IDLE : bfs_pkg::ST_EMIT;
			default: st_d = bfs_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		req.ready = (st_q == bfs_pkg::ST_IDLE);
		res.valid = (st_q == bfs_pkg::ST_EMIT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= bfs_pkg::ST_IDLE;
		else st_q <= st_d;
	end

	// graph tables
	always_ff @(posedge clk) begin
		if (accept && req.action == bfs_pkg::ACT_START && req.position <= {2'b00, bfs_pkg::NodeLimit})
			es_mem[req.position[10:0]] <= req.value;
		es_rd_q <= es_mem[es_addr];
		if (accept && req.action == bfs_pkg::ACT_NEIGH)
			nb_mem[req.position] <= {|req.value[13:10], req.value[9:0]};
		nb_rd_q <= nb_mem[nb_addr];
	end

	// visited map
	always_ff @(posedge clk) begin
		vis_rd_q <= vis_mem[nb_rd_q[9:0]];
		if (st_q == bfs_pkg::ST_CLEAR)
			vis_mem[clr_q[9:0]] <= 1'b0;
		else if (st_q == bfs_pkg::ST_SEED)
			vis_mem[u_q] <= 1'b1;
		else if (st_q == bfs_pkg::ST_EDGE2 && nb_ok)
			vis_mem[nb_rd_q[9:0]] <= 1'b1;
	end

	// work queue: node index and depth
	always_ff @(posedge clk) begin
		q_rd_q <= q_mem[head_q[9:0]];
		if (st_q == bfs_pkg::ST_SEED)
			q_mem[10'd0] <= {u_q, 5'd0};
		else if (st_q == bfs_pkg::ST_EDGE2 && nb_ok)
			q_mem[tail_q[9:0]] <= {nb_rd_q[9:0], nd};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0; tail_q <= '0; clr_q <= '0; deep_q <= '0; emd_q <= '0;
			u_q <= '0; ud_q <= '0; lo_q <= '0; hi_q <= '0; src_ok_q <= 1'b0;
			for (int i = 0; i < bfs_pkg::MaxDepth; i++) cnt_q[i] <= '0;
		end else begin
			case (st_q)
				bfs_pkg::ST_IDLE: if (run_go) begin
					clr_q <= '0; head_q <= '0; tail_q <= '0; deep_q <= '0; emd_q <= '0;
					for (int i = 0; i < bfs_pkg::MaxDepth; i++) cnt_q[i] <= '0;
					u_q <= req.value[9:0];
					src_ok_q <= (req.value < {3'd0, n_eff});
				end
				bfs_pkg::ST_CLEAR: clr_q <= clr_q + 11'd1;
				bfs_pkg::ST_SEED: tail_q <= 11'd1;
				bfs_pkg::ST_POP: if (head_q < tail_q)
					head_q <= head_q + 11'd1;
				bfs_pkg::ST_LO: begin
					u_q <= q_rd_q[14:5];
					ud_q <= q_rd_q[4:0];
				end
				bfs_pkg::ST_HI: lo_q <= es_clamp;
				bfs_pkg::ST_RANGE: hi_q <= es_clamp;
				bfs_pkg::ST_EDGE2: begin
					if (nb_ok) tail_q <= tail_q + 11'd1;
					lo_q <= lo_nx;
				end
				bfs_pkg::ST_NEXT: begin
					cnt_q[ud_q] <= cnt_q[ud_q] + 11'd1;
					if (ud_q > deep_q) deep_q <= ud_q;
				end
				bfs_pkg::ST_EMIT: if (res.ready)
					emd_q <= emd_q + 5'd1;
				default: ;
			endcase
		end
	end

	assign res.depth = emd_q;
	assign res.path_count = cnt_q[emd_q];
	assign res.last = (emd_q == deep_q);

`ifndef SYNTH
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> !req.ready) else $error("ready during emit");
	a_tail: assert property (@(posedge clk) disable iff (!arst_n)
		head_q <= tail_q) else $error("head past tail");
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		tail_q <= bfs_pkg::NodeLimit) else $error("queue overrun");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.ready |=> res.valid && $stable(res.depth) &&
		$stable(res.path_count) && $stable(res.last)) else $error("result not held");
`endif
endmodule
`default_nettype wire
